/* hw/rtl/vilt_pkg.sv */
// Shared types and constants for the video interface line timer.
// Used by vilt_ctrl, vilt_dp and video_interface_line_timer. No dependencies.
`default_nettype none

package vilt_pkg;

  // field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 20;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] IDX_ORIGIN  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_INTR    = 4'd3;
  localparam logic [IDX_W-1:0] IDX_CURRENT = 4'd4;
  localparam logic [IDX_W-1:0] IDX_VSYNC   = 4'd6;

  // frame timing: start value is START_NUM / START_DEN
  localparam int NUM_W     = 26;
  localparam int START_NUM = 62500060;
  localparam int START_DEN = 60;
  localparam logic [CNT_W-1:0] START_VAL = CNT_W'(START_NUM / START_DEN);

  // reciprocal divider: 32 quotient bits, numerator up to NUM_W + 32 bits,
  // estimate, remainder and correction steps
  localparam int QUO_W     = 32;
  localparam int PROD_W    = NUM_W + QUO_W;
  localparam int DIV_STEPS = 3;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // parameter defaults
  localparam int REG_COUNT_DEF       = 16;
  localparam int LINES_PER_FRAME_DEF = 525;
  localparam int BLANK_LINES_DEF     = 39;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] write_mask;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_raise;
    logic              irq_clear;
    logic              frame_done;
    logic              field_now;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take the input word
    logic prep;     // register the product
    logic step;     // one divider step
    logic commit;   // update state and load output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;  // input word needs a division
    logic div_last;  // this step is the last divider step
    logic out_free;  // output register can take a word
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/vilt_ctrl.sv */
// Sequencer for the video interface line timer.
// Depends on vilt_pkg.
`default_nettype none

module vilt_ctrl
  import vilt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREP   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.need_div ? ST_PREP : ST_COMMIT;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vilt_dp.sv */
// Datapath of the video interface line timer: counter, register file,
// shared reciprocal divider and output register. Depends on vilt_pkg.
`default_nettype none

module vilt_dp
  import vilt_pkg::*;
#(
  parameter int REG_COUNT       = REG_COUNT_DEF,
  parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF,
  parameter int BLANK_LINES     = BLANK_LINES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_data,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_word_t     out_data,
  input  wire ctl_cmd_t cmd,
  output dp_sts_t       sts
);

  localparam int RIDX_W = $clog2(REG_COUNT);
  localparam int LINE_W = $clog2(LINES_PER_FRAME + 1);
  localparam logic [63:0] BLANK_FULL =
      (64'(START_NUM) * 64'(LINES_PER_FRAME - BLANK_LINES)) /
      (64'(START_DEN) * 64'(LINES_PER_FRAME));
  localparam logic [CNT_W-1:0] BLANK_VAL = BLANK_FULL[CNT_W-1:0];
  localparam logic [NUM_W-1:0] DEN_CMP   = NUM_W'(START_DEN * LINES_PER_FRAME);

  // quotient estimate: top 32 bits of the numerator times 2^(SH+32)/divisor.
  // Read numerators stay below 2^57, intr numerators below 2^36.
  localparam int REM_W  = NUM_W + 2;
  localparam int RD_SH  = 25;
  localparam int CMP_SH = 4;
  localparam logic [QUO_W-1:0] RECIP_RD =
      QUO_W'((64'd1 << (RD_SH + QUO_W)) / 64'(START_NUM));
  localparam logic [QUO_W-1:0] RECIP_CMP =
      QUO_W'((64'd1 << (CMP_SH + QUO_W)) / 64'(START_DEN * LINES_PER_FRAME));

  localparam logic [STEP_W-1:0] STEP_EST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_REM = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_FIX = STEP_W'(DIV_STEPS - 1);

  in_word_t          item_r;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [CNT_W-1:0]  cmp_r, cmp_nxt;
  logic              field_r, field_nxt;
  logic [WORD_W-1:0] reg_r [REG_COUNT];
  logic [PROD_W-1:0] x_r;
  logic [QUO_W-1:0]  qe_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              out_valid_r;
  out_word_t         out_r, res;

  // prep path
  logic [WORD_W-1:0] vsync;
  logic [NUM_W-1:0]  span, diff;
  logic [30:0]       k;
  logic [LINE_W-1:0] m;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  den_sel;

  // divider steps
  logic [QUO_W-1:0]  x_hi;
  logic [QUO_W-1:0]  recip;
  logic [QUO_W-1:0]  est;
  logic [REM_W-1:0]  rem_nxt;
  logic [1:0]        fix;

  // commit path
  logic [CNT_W-1:0]  dec;
  logic [WORD_W-1:0] cur_val;
  logic              in_range;
  logic [RIDX_W-1:0] ridx;

  assign vsync = reg_r[RIDX_W'(IDX_VSYNC)];
  assign ridx  = item_r.reg_index[RIDX_W-1:0];
  assign in_range = ({1'b0, item_r.reg_index} < 5'(REG_COUNT));

  // numerator and divisor for the division ahead
  always_comb begin
    span = NUM_W'(fc_r) * NUM_W'(START_DEN);
    diff = (span > NUM_W'(START_NUM)) ? '0 : NUM_W'(START_NUM) - span;
    k    = item_r.write_data[31:1];
    m    = (k > 31'(LINES_PER_FRAME)) ? '0 : LINE_W'(31'(LINES_PER_FRAME) - k);
    if (item_r.opcode == OP_READ) begin
      prod    = PROD_W'(diff) * PROD_W'(vsync[31:1]);
      den_sel = NUM_W'(START_NUM);
    end else begin
      prod    = PROD_W'(NUM_W'(START_NUM)) * PROD_W'(m);
      den_sel = DEN_CMP;
    end
  end

  // divide by a constant: the estimate is at most 2 below the quotient,
  // the remainder (below 3x divisor) fits REM_W bits and fixes it up
  always_comb begin
    if (item_r.opcode == OP_READ) begin
      x_hi  = x_r[RD_SH+QUO_W-1:RD_SH];
      recip = RECIP_RD;
    end else begin
      x_hi  = x_r[CMP_SH+QUO_W-1:CMP_SH];
      recip = RECIP_CMP;
    end
    est     = QUO_W'(({{QUO_W{1'b0}}, x_hi} * {{QUO_W{1'b0}}, recip}) >> QUO_W);
    rem_nxt = x_r[REM_W-1:0] - (qe_r[REM_W-1:0] * REM_W'(den_sel));
    if (rem_r >= REM_W'({den_sel, 1'b0})) begin
      fix = 2'd2;
    end else if (rem_r >= REM_W'(den_sel)) begin
      fix = 2'd1;
    end else begin
      fix = 2'd0;
    end
  end

  always_comb begin
    dec       = fc_r - 1'b1;
    fc_nxt    = fc_r;
    cmp_nxt   = cmp_r;
    field_nxt = field_r;
    res       = '0;
    if (vsync < 32'd2) begin
      cur_val = '0;
    end else begin
      cur_val = {quo_r[30:0], 1'b0} | {31'd0, ~vsync[0] & field_r};
    end
    case (item_r.opcode)
      OP_TICK: begin
        fc_nxt = (dec == '0) ? START_VAL : dec;
        res.irq_raise = (dec == cmp_r);
        if (dec == BLANK_VAL) begin
          field_nxt      = ~field_r;
          res.frame_done = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) begin
          res.read_data = (item_r.reg_index == IDX_CURRENT) ? cur_val : reg_r[ridx];
        end
      end
      OP_WRITE: begin
        if (item_r.reg_index == IDX_CURRENT) begin
          res.irq_clear = 1'b1;
        end else if (in_range && item_r.reg_index == IDX_INTR) begin
          cmp_nxt = quo_r[CNT_W-1:0];
        end
      end
      default: ;
    endcase
    res.field_now = field_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.prep) x_r <= prod;
    if (cmd.step) begin
      case (cnt_r)
        STEP_EST: qe_r  <= est;
        STEP_REM: rem_r <= rem_nxt;
        default:  quo_r <= qe_r + QUO_W'(fix);
      endcase
    end
    if (cmd.commit) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= START_VAL;
      cmp_r       <= '0;
      field_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) reg_r[i] <= '0;
    end else begin
      if (cmd.prep) cnt_r <= '0;
      else if (cmd.step) cnt_r <= cnt_r + 1'b1;
      if (cmd.commit) begin
        fc_r    <= fc_nxt;
        cmp_r   <= cmp_nxt;
        field_r <= field_nxt;
        if (item_r.opcode == OP_READ) begin
          reg_r[RIDX_W'(IDX_CURRENT)] <= cur_val;
        end else if (item_r.opcode == OP_WRITE && in_range &&
                     item_r.reg_index != IDX_CURRENT) begin
          reg_r[ridx] <= (reg_r[ridx] & ~item_r.write_mask) | item_r.write_data;
        end
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.need_div = (in_data.opcode == OP_READ) ||
                        (in_data.opcode == OP_WRITE && in_data.reg_index == IDX_INTR);
  assign sts.div_last = (cnt_r == STEP_FIX);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/video_interface_line_timer.sv */
// Top level of the video interface line timer: controller plus datapath.
// Depends on vilt_pkg, vilt_ctrl and vilt_dp.
//
//   channel | ports                          | word
//   --------+--------------------------------+-----------
//   input   | in_valid, in_ready, in_data    | in_word_t
//   result  | out_valid, out_ready, out_data | out_word_t
//
// One item at a time. Ticks, plain writes and opcode 3 go through accept
// and commit. Register reads and writes to INTR go through accept, the
// product step, three divider steps (reciprocal estimate, remainder,
// correction) and commit. The divider sets the read rate.
// Reset (rst_n low, synchronous) loads the counter start value and
// clears compare, field bit, register file and output valid.
// Commit waits while the output register holds an untaken word; the next
// item is accepted as soon as the commit is done.
`default_nettype none

module video_interface_line_timer
  import vilt_pkg::*;
#(
  parameter int REG_COUNT       = REG_COUNT_DEF,
  parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF,
  parameter int BLANK_LINES     = BLANK_LINES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: idle, product, divide, commit
  vilt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counter, registers, divider and output register
  vilt_dp #(
    .REG_COUNT       (REG_COUNT),
    .LINES_PER_FRAME (LINES_PER_FRAME),
    .BLANK_LINES     (BLANK_LINES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

/* sim/tb_video_interface_line_timer.sv */
// Self-checking testbench for video_interface_line_timer: random valid/ready traffic,
// a built-in predictor of the frame counter, compare, field bit and register file.
// Depends on vilt_pkg and the RTL under hw/rtl.
module tb_video_interface_line_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import vilt_pkg::*;

  // opcode 3 has no meaning in the block; it must leave all state alone
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int LINES = LINES_PER_FRAME_DEF;
  localparam int BLANK = BLANK_LINES_DEF;
  localparam int IDLE_PCT = 38;
  localparam int TAIL_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  video_interface_line_timer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // a pending word; calm words are sent (and their results taken) with no idling,
  // a drain word waits until every outstanding result has come back
  typedef struct {
    in_word_t w;
    bit       calm;
    bit       drain;
  } pend_t;

  pend_t     pend_q[$];
  out_word_t expect_q[$];
  int        fail_count = 0;
  bit        calm_run = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the block's counter, compare, field and registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  vt_cnt;
  logic [CNT_W-1:0]  vt_cmp;
  logic              vt_field;
  logic [WORD_W-1:0] vt_regs [16];

  // counter value that corresponds to the start of line k:
  // floor(S * (LINES - k) / LINES), S = START_NUM / START_DEN, k saturated to LINES
  function automatic logic [CNT_W-1:0] line_compare(longint unsigned k);
    longint unsigned snum, n;
    snum = START_NUM;
    if (k > LINES) k = LINES;
    n = snum * (LINES - k);
    return CNT_W'(n / (START_DEN * LINES));
  endfunction

  // half-line number for the current register, exact rationals
  function automatic logic [WORD_W-1:0] half_line();
    logic [WORD_W-1:0] v, r;
    longint unsigned   snum, h, span, q;
    snum = START_NUM;
    v = vt_regs[IDX_VSYNC];
    if (v < 2) return '0;
    h = v >> 1;
    span = longint'(vt_cnt) * START_DEN;
    if (span > snum) q = 0;
    else q = (snum - span) * h / snum;
    r = WORD_W'(q << 1);
    if (!v[0]) r[0] = r[0] | vt_field;
    return r;
  endfunction

  function automatic void clear_timer();
    vt_cnt = START_VAL;
    vt_cmp = '0;
    vt_field = 1'b0;
    foreach (vt_regs[i]) vt_regs[i] = '0;
  endfunction

  // advance the predictor by one accepted word and return its result word
  function automatic out_word_t timer_step(in_word_t w);
    out_word_t        o;
    logic [CNT_W-1:0] c;
    o = '0;
    case (w.opcode)
      OP_TICK: begin
        c = vt_cnt - 1'b1;
        vt_cnt = (c == '0) ? START_VAL : c;
        o.irq_raise = (c == vt_cmp);
        if (c == line_compare(BLANK)) begin
          vt_field = ~vt_field;
          o.frame_done = 1'b1;
        end
      end
      OP_READ: begin
        // every read refreshes the current-line register first
        vt_regs[IDX_CURRENT] = half_line();
        o.read_data = vt_regs[w.reg_index];
      end
      OP_WRITE: begin
        if (w.reg_index == IDX_CURRENT) begin
          o.irq_clear = 1'b1;   // ack only, register untouched
        end else begin
          if (w.reg_index == IDX_INTR) vt_cmp = line_compare(w.write_data >> 1);
          vt_regs[w.reg_index] = (vt_regs[w.reg_index] & ~w.write_mask) | w.write_data;
        end
      end
      default: ;
    endcase
    o.field_now = vt_field;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents words from pend_q, predicts each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic     nv;
    in_word_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      clear_timer();
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expect_q.push_back(timer_step(in_data));
        nv = 1'b0;
      end
      if (!nv && pend_q.size() != 0 && !(pend_q[0].drain && expect_q.size() != 0)) begin
        if (pend_q[0].calm || $urandom_range(99) >= IDLE_PCT) begin
          nv = 1'b1;
          nd = pend_q[0].w;
          calm_run <= pend_q[0].calm;
          pend_q.pop_front();
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare against expect_q
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [WORD_W-1:0] e, logic [WORD_W-1:0] a);
    if (a !== e) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with none expected, expected none, got %h",
                   $time, out_data);
        end else begin
          e = expect_q.pop_front();
          check_field("read_data", e.read_data, out_data.read_data);
          check_field("irq_raise", WORD_W'(e.irq_raise), WORD_W'(out_data.irq_raise));
          check_field("irq_clear", WORD_W'(e.irq_clear), WORD_W'(out_data.irq_clear));
          check_field("frame_done", WORD_W'(e.frame_done), WORD_W'(out_data.frame_done));
          check_field("field_now", WORD_W'(e.field_now), WORD_W'(out_data.field_now));
        end
      end
      out_ready <= calm_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corner words, then random bursts with the intr line
  // stepped upward.
  // --------------------------------------------------------------------------
  bit hold_next = 1'b0;

  task automatic queue_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                            logic [WORD_W-1:0] data, logic [WORD_W-1:0] mask, bit calm);
    pend_t p;
    p.w = '{opcode: op, reg_index: idx, write_data: data, write_mask: mask};
    p.calm = calm;
    p.drain = hold_next;
    hold_next = 1'b0;
    pend_q.push_back(p);
  endtask

  // small values, all ones or fully random
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(3))
      0: return WORD_W'($urandom_range(3));
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // one random word; intr writes mostly land near line ln
  task automatic queue_random(int ln, bit calm);
    int              sel, k;
    logic [IDX_W-1:0] idx;
    sel = $urandom_range(99);
    idx = IDX_W'($urandom_range(15));
    if (sel < 40) begin
      queue_word(OP_TICK, idx, $urandom(), $urandom(), calm);
    end else if (sel < 65) begin
      if ($urandom_range(1)) idx = IDX_CURRENT;
      queue_word(OP_READ, idx, $urandom(), $urandom(), calm);
    end else if (sel < 95) begin
      case ($urandom_range(4))
        0: queue_word(OP_WRITE, IDX_VSYNC, pick_word(), pick_word(), calm);
        1: begin
          k = ln - 2 + $urandom_range(4);
          if (k < 0) k = 0;
          queue_word(OP_WRITE, IDX_INTR, WORD_W'(k << 1) | WORD_W'($urandom_range(1)),
                     pick_word(), calm);
        end
        default: queue_word(OP_WRITE, idx, pick_word(), pick_word(), calm);
      endcase
    end else begin
      queue_word(OP_NONE, idx, $urandom(), $urandom(), calm);
    end
  endtask

  initial begin : stim
    int              ln;
    bit              calm;

    // directed: empty vsync, unused opcode, current-register ack, vsync edges,
    // intr line past the frame and line zero, last index, masked writes
    queue_word(OP_READ, IDX_CURRENT, '0, '0, 1'b0);
    queue_word(OP_NONE, 4'hF, '1, '1, 1'b0);
    queue_word(OP_TICK, '0, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_CURRENT, '1, '1, 1'b0);
    queue_word(OP_READ, IDX_CURRENT, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_VSYNC, 32'd1, '1, 1'b0);
    queue_word(OP_READ, IDX_CURRENT, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_VSYNC, 32'd2, '1, 1'b0);
    queue_word(OP_READ, IDX_CURRENT, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_VSYNC, 32'hFFFF_FFFE, '1, 1'b0);
    queue_word(OP_READ, IDX_CURRENT, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_VSYNC, '1, '0, 1'b0);
    queue_word(OP_READ, 4'hF, '1, '1, 1'b0);
    queue_word(OP_WRITE, IDX_INTR, '1, '1, 1'b0);
    queue_word(OP_READ, IDX_INTR, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_INTR, '0, '1, 1'b0);
    queue_word(OP_TICK, 4'hF, '1, '1, 1'b0);
    queue_word(OP_WRITE, 4'hF, '1, '0, 1'b0);
    queue_word(OP_READ, 4'hF, '0, '0, 1'b0);
    queue_word(OP_WRITE, 4'hF, '0, '1, 1'b0);
    queue_word(OP_READ, 4'hF, '0, '0, 1'b0);
    queue_word(OP_WRITE, IDX_ORIGIN, 32'hA5A5_A5A5, '0, 1'b0);
    queue_word(OP_WRITE, IDX_ORIGIN, 32'h0000_5A5A, 32'hFFFF_0000, 1'b0);
    queue_word(OP_READ, IDX_ORIGIN, '0, '0, 1'b0);
    queue_word(OP_READ, '0, '0, '0, 1'b0);

    // step the intr line upward: a random burst, then aim the compare at the line
    for (ln = 1; ln <= BLANK + 1; ln++) begin
      calm = (ln >= 10 && ln < 15);   // one long stretch with no idling on either side
      repeat (36) queue_random(ln, calm);
      if (ln == 20) hold_next = 1'b1;   // let the block run dry once
      queue_word(OP_WRITE, IDX_INTR, WORD_W'(ln << 1) | WORD_W'($urandom_range(1)),
                 pick_word(), calm);
    end
    // closing random traffic
    repeat (50) queue_random(BLANK + 2, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid || expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(60_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
